[hdl/dequ_pkg.sv]
package dequ_pkg;

    localparam logic [1:0] FUNC_PUSH_FRONT  = 2'd0;
    localparam logic [1:0] FUNC_POP_FRONT   = 2'd1;
    localparam logic [1:0] FUNC_INJECT_REAR = 2'd2;
    localparam logic [1:0] FUNC_EJECT_REAR  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int unsigned PORT_BITS = 32;

    typedef struct packed {
        logic [1:0]                  func;
        logic signed [PORT_BITS-1:0] value;
    } dequ_in_t;

    typedef struct packed {
        logic signed [PORT_BITS-1:0] data_out;
        logic [1:0]                  status;
    } dequ_out_t;

    // what travels with an item from the pointer stage to the result stage
    typedef struct packed {
        logic       rd;
        logic [1:0] status;
    } dequ_res_ctl_t;

endpackage

[hdl/double_ended_queue.sv]
// channel   | ports                       | payload
// ----------+-----------------------------+------------------------------
// operation | s_valid s_ready s_data      | dequ_in_t  (func, value)
// result    | m_valid m_ready m_data      | dequ_out_t (data_out, status)
//
// one item per cycle sustained while m_ready stays high; the ring store read of an
// item is registered in the store's read data, then loaded into the output register.
// pointers and occupancy update on an OK accept, so the next item may follow at once.
// aresetn (synchronous) empties the deque; the ring store itself is not cleared.
// a stalled result holds the output register and one further item in flight.
module double_ended_queue #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dequ_pkg::dequ_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dequ_pkg::dequ_out_t m_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                    accept;
    logic                    mem_we, mem_re;
    logic [PTR_W-1:0]        mem_addr;
    logic [WORD_BITS-1:0]    wr_data, rd_data;
    logic [63:0]             val_wide, rd_wide;
    dequ_pkg::dequ_res_ctl_t res_ctl;

    logic                    pend_reg, pend_next;
    dequ_pkg::dequ_res_ctl_t pend_ctl_reg;
    logic                    out_valid_reg, out_valid_next;
    dequ_pkg::dequ_out_t     out_reg;
    logic                    out_load;

    assign out_load = pend_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !pend_reg || out_load;
    assign accept   = s_valid && s_ready;

    assign val_wide = {32'b0, s_data.value};
    assign wr_data  = val_wide[WORD_BITS-1:0];
    assign rd_wide  = 64'(rd_data);

    dequ_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .func    (s_data.func),
        .mem_we  (mem_we),
        .mem_re  (mem_re),
        .mem_addr(mem_addr),
        .res_ctl (res_ctl)
    );

    dequ_mem #(
        .DEPTH    (DEPTH),
        .WORD_BITS(WORD_BITS)
    ) u_mem (
        .aclk   (aclk),
        .we     (mem_we),
        .re     (mem_re),
        .addr   (mem_addr),
        .wr_data(wr_data),
        .rd_data(rd_data)
    );

    assign pend_next      = accept ? 1'b1 : (out_load ? 1'b0 : pend_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_ctl_reg <= res_ctl;
        end
        if (out_load) begin
            out_reg.data_out <= pend_ctl_reg.rd ? rd_wide[31:0] : '0;
            out_reg.status   <= pend_ctl_reg.status;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[hdl/dequ_mem.sv]
module dequ_mem #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    input  logic [WORD_BITS-1:0]         wr_data,
    output logic [WORD_BITS-1:0]         rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/dequ_ctrl.sv]
module dequ_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [1:0]                    func,
    output logic                          mem_we,
    output logic                          mem_re,
    output logic [$clog2(DEPTH)-1:0]      mem_addr,
    output dequ_pkg::dequ_res_ctl_t       res_ctl
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    logic [PTR_W-1:0] head_prev, head_inc, tail_prev, tail_inc;
    logic             is_add, full, empty, ok;
    logic [1:0]       status;

    assign head_prev = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);
    assign head_inc  = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign tail_prev = (tail_reg == '0) ? PTR_LAST : tail_reg - PTR_W'(1);
    assign tail_inc  = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);

    assign is_add = (func == dequ_pkg::FUNC_PUSH_FRONT) || (func == dequ_pkg::FUNC_INJECT_REAR);
    assign full   = (occ_reg == CNT_FULL);
    assign empty  = (occ_reg == '0);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        status    = dequ_pkg::STATUS_OK;
        mem_addr  = tail_reg;
        case (func)
            dequ_pkg::FUNC_PUSH_FRONT: begin
                mem_addr  = head_prev;
                head_next = head_prev;
                if (full) status = dequ_pkg::STATUS_FULL;
            end
            dequ_pkg::FUNC_POP_FRONT: begin
                mem_addr  = head_reg;
                head_next = head_inc;
                if (empty) status = dequ_pkg::STATUS_EMPTY;
            end
            dequ_pkg::FUNC_INJECT_REAR: begin
                mem_addr  = tail_reg;
                tail_next = tail_inc;
                if (full) status = dequ_pkg::STATUS_FULL;
            end
            default: begin
                mem_addr  = tail_prev;
                tail_next = tail_prev;
                if (empty) status = dequ_pkg::STATUS_EMPTY;
            end
        endcase
    end

    assign ok       = (status == dequ_pkg::STATUS_OK);
    assign occ_next = is_add ? occ_reg + CNT_W'(1) : occ_reg - CNT_W'(1);

    assign mem_we = accept && ok && is_add;
    assign mem_re = accept && ok && !is_add;

    assign res_ctl.rd     = ok && !is_add;
    assign res_ctl.status = status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else if (accept && ok) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

endmodule
